// ===== src/urld_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the segment decoder for the ultrasonic ranger.
// No dependencies; imported by urld_echo_timer and the top level.
package urld_pkg;

    localparam int DIST_W   = 11;
    localparam int CODE_W   = 4;
    localparam int ACC_W    = 10;
    localparam int SCAN_W   = 16;
    localparam int STEPS_W  = 10;
    localparam int TRIG_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [DIST_W-1:0] DIST_MAX  = 11'd2047;
    // distance = count * 17 / 1000, tracked as a running remainder
    localparam logic [ACC_W:0]    ACC_STEP  = 11'd17;
    localparam logic [ACC_W:0]    ACC_MOD   = 11'd1000;
    localparam logic [CODE_W-1:0] DASH_CODE = 4'd10;
    localparam logic [7:0]        DP_MASK   = 8'h7F;
    localparam logic [7:0]        SEG_OFF   = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE        = 2'd3;

    typedef struct packed {
        logic              done;
        logic              range_bad;
        logic [DIST_W-1:0] distance;
    } t_meas;

    // active-low common-anode pattern, bit7 point, bits0-6 a-g
    function automatic logic [7:0] seg_code(input logic [CODE_W-1:0] code);
        logic [7:0] seg;
        unique case (code)
            4'd0:    seg = 8'hC0;
            4'd1:    seg = 8'hF9;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hF8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            4'd10:   seg = 8'hBF;
            default: seg = SEG_OFF;
        endcase
        return seg;
    endfunction

endpackage

// ===== src/urld_echo_timer.sv =====
`timescale 1ns / 1ps
// Echo pulse timer: counts ticks while echo is high and keeps the distance and
// its decimal digits up to date incrementally. Depends on urld_pkg.
module urld_echo_timer #(
    parameter int COUNT_BITS = 16,
    parameter int NUM_DIGITS = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic                        i_echo,
    input  logic [urld_pkg::DIST_W-1:0] i_max_range,
    output urld_pkg::t_meas             o_meas,
    output logic [urld_pkg::CODE_W-1:0] o_next_codes [NUM_DIGITS]
);
    import urld_pkg::*;

    logic                  r_echo_prev, n_echo_prev;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_ovf, n_ovf;
    logic [ACC_W-1:0]      r_acc, n_acc;
    logic [DIST_W-1:0]     r_quot, n_quot;
    logic [CODE_W-1:0]     r_bcd [NUM_DIGITS];
    logic [CODE_W-1:0]     n_bcd [NUM_DIGITS];
    logic [CODE_W-1:0]     r_codes [NUM_DIGITS];
    logic [CODE_W-1:0]     n_codes [NUM_DIGITS];
    t_meas                 r_meas, n_meas;

    logic [COUNT_BITS-1:0] count_inc;
    logic [ACC_W:0]        acc_sum;
    logic [CODE_W-1:0]     bcd_inc [NUM_DIGITS];
    logic                  range_bad;

    assign count_inc = r_count + COUNT_BITS'(1);
    assign acc_sum   = {1'b0, r_acc} + ACC_STEP;
    assign range_bad = (r_quot >= i_max_range) || r_ovf;

    // decimal increment of the low digits, ones digit last in the array
    always_comb begin
        logic carry;
        carry = 1'b1;
        for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
            if (carry && (r_bcd[k] == 4'd9)) begin
                bcd_inc[k] = '0;
            end else if (carry) begin
                bcd_inc[k] = r_bcd[k] + 4'd1;
                carry = 1'b0;
            end else begin
                bcd_inc[k] = r_bcd[k];
            end
        end
    end

    always_comb begin
        n_echo_prev = r_echo_prev;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_acc       = r_acc;
        n_quot      = r_quot;
        n_bcd       = r_bcd;
        n_codes     = r_codes;
        n_meas      = r_meas;
        if (i_step) begin
            n_echo_prev  = i_echo;
            n_meas.done  = 1'b0;
            if (i_echo) begin
                n_count = count_inc;
                if (count_inc == '0) begin
                    // counter wrapped: distance restarts from zero
                    n_ovf  = 1'b1;
                    n_acc  = '0;
                    n_quot = '0;
                    for (int k = 0; k < NUM_DIGITS; k++) n_bcd[k] = '0;
                end else if (acc_sum >= ACC_MOD) begin
                    n_acc  = ACC_W'(acc_sum - ACC_MOD);
                    n_quot = (r_quot == DIST_MAX) ? r_quot : r_quot + DIST_W'(1);
                    n_bcd  = bcd_inc;
                end else begin
                    n_acc = ACC_W'(acc_sum);
                end
            end else if (r_echo_prev) begin
                // falling edge: latch the measurement
                n_meas.done      = 1'b1;
                n_meas.range_bad = range_bad;
                n_meas.distance  = r_quot;
                for (int k = 0; k < NUM_DIGITS; k++) begin
                    n_codes[k] = range_bad ? DASH_CODE : r_bcd[k];
                    n_bcd[k]   = '0;
                end
                n_count = '0;
                n_ovf   = 1'b0;
                n_acc   = '0;
                n_quot  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_prev <= 1'b0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_acc       <= '0;
            r_quot      <= '0;
            r_meas      <= '0;
            for (int k = 0; k < NUM_DIGITS; k++) begin
                r_bcd[k]   <= '0;
                r_codes[k] <= '0;
            end
        end else begin
            r_echo_prev <= n_echo_prev;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_acc       <= n_acc;
            r_quot      <= n_quot;
            r_meas      <= n_meas;
            r_bcd       <= n_bcd;
            r_codes     <= n_codes;
        end
    end

    assign o_meas       = r_meas;
    assign o_next_codes = n_codes;

endmodule

// ===== src/ultrasonic_ranger_with_led_display_unit.sv =====
`timescale 1ns / 1ps
// Top level of the ultrasonic ranger: handshake, configuration, display scan
// and trigger generation. Depends on urld_pkg and urld_echo_timer.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_echo_level
//  out     | output    | o_out_valid / i_out_ready  | o_trigger_out .. o_out_of_range
//  cfg     | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// One tick per cycle while o_in_ready is high: each transfer in produces its
// result in the output register in the cycle after it is accepted.
// Input ready is held low only while a result waits and the output is stalled.
// Synchronous active-low reset clears all state; configuration returns to
// 2000 / 400 / 21 / 700.
module ultrasonic_ranger_with_led_display_unit #(
    parameter int COUNT_BITS = 16,
    parameter int NUM_DIGITS = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_echo_level,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_trigger_out,
    output logic [7:0]                      o_segments_n,
    output logic [NUM_DIGITS-1:0]           o_digit_select_n,
    output logic [urld_pkg::DIST_W-1:0]     o_distance_cm,
    output logic                            o_measure_done,
    output logic                            o_out_of_range,
    input  logic                            i_cfg_we,
    input  logic [urld_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [urld_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import urld_pkg::*;

    localparam int POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    logic [SCAN_W-1:0]     r_scan_period;
    logic [STEPS_W-1:0]    r_trig_interval;
    logic [TRIG_W-1:0]     r_trig_width;
    logic [DIST_W-1:0]     r_max_range;

    logic                  r_out_valid, n_out_valid;
    logic [SCAN_W-1:0]     r_scan_tick, n_scan_tick;
    logic [STEPS_W-1:0]    r_scan_steps, n_scan_steps;
    logic [TRIG_W-1:0]     r_trig_left, n_trig_left;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [7:0]            r_segment, n_segment;
    logic [NUM_DIGITS-1:0] r_select, n_select;
    logic                  r_trigger, n_trigger;

    logic                  accept;
    logic [SCAN_W-1:0]     tick_inc;
    logic [STEPS_W-1:0]    steps_inc;
    logic [TRIG_W-1:0]     trig_mid;
    logic [POS_W-1:0]      sel_shift;
    logic                  scan_hit;
    t_meas                 meas;
    logic [CODE_W-1:0]     next_codes [NUM_DIGITS];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    urld_echo_timer #(
        .COUNT_BITS (COUNT_BITS),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_timer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (accept),
        .i_echo       (i_echo_level),
        .i_max_range  (r_max_range),
        .o_meas       (meas),
        .o_next_codes (next_codes)
    );

    assign tick_inc  = r_scan_tick + SCAN_W'(1);
    assign steps_inc = r_scan_steps + STEPS_W'(1);
    assign scan_hit  = tick_inc >= r_scan_period;
    assign sel_shift = POS_W'(NUM_DIGITS - 1) - r_pos;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_scan_tick  = r_scan_tick;
        n_scan_steps = r_scan_steps;
        n_trig_left  = r_trig_left;
        n_pos        = r_pos;
        n_segment    = r_segment;
        n_select     = r_select;
        n_trigger    = r_trigger;
        trig_mid     = r_trig_left;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (accept) begin
            n_scan_tick = tick_inc;
            if (scan_hit) begin
                n_scan_tick = '0;
                // digit shown uses the codes as updated by this tick
                n_segment = seg_code(next_codes[r_pos]);
                if (r_pos == '0) n_segment = n_segment & DP_MASK;
                n_select = ~(NUM_DIGITS'(1) << sel_shift);
                n_pos = (r_pos == POS_W'(NUM_DIGITS - 1)) ? '0 : r_pos + POS_W'(1);
                n_scan_steps = steps_inc;
                if (steps_inc >= r_trig_interval) begin
                    n_scan_steps = '0;
                    trig_mid     = r_trig_width;
                end
            end
            // pulse started on this tick is already high
            n_trigger   = (trig_mid != '0);
            n_trig_left = (trig_mid != '0) ? trig_mid - TRIG_W'(1) : trig_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_period   <= 16'd2000;
            r_trig_interval <= 10'd400;
            r_trig_width    <= 8'd21;
            r_max_range     <= 11'd700;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCAN_PERIOD:      r_scan_period   <= i_cfg_data;
                CFG_TRIGGER_INTERVAL: r_trig_interval <= i_cfg_data[STEPS_W-1:0];
                CFG_TRIGGER_WIDTH:    r_trig_width    <= i_cfg_data[TRIG_W-1:0];
                CFG_MAX_RANGE:        r_max_range     <= i_cfg_data[DIST_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_scan_tick  <= '0;
            r_scan_steps <= '0;
            r_trig_left  <= '0;
            r_pos        <= '0;
            r_segment    <= SEG_OFF;
            r_select     <= '1;
            r_trigger    <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_scan_tick  <= n_scan_tick;
            r_scan_steps <= n_scan_steps;
            r_trig_left  <= n_trig_left;
            r_pos        <= n_pos;
            r_segment    <= n_segment;
            r_select     <= n_select;
            r_trigger    <= n_trigger;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_trigger_out    = r_trigger;
    assign o_segments_n     = r_segment;
    assign o_digit_select_n = r_select;
    assign o_distance_cm    = meas.distance;
    assign o_measure_done   = meas.done;
    assign o_out_of_range   = meas.range_bad;

endmodule
